/* hw/rtl/csc_pkg.sv */
// csc_pkg: shared types and constants for the census stereo cost block.
// Used by every module under hw/rtl; depends on nothing.
package csc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 2048;
  localparam int MAX_DISP   = 64;
  localparam int WIN_W      = 9;
  localparam int WIN_H      = 7;
  localparam int HW         = (WIN_W - 1) / 2;
  localparam int HH         = (WIN_H - 1) / 2;
  localparam int WIN_N      = WIN_W * WIN_H;
  localparam int STORE_ROWS = WIN_H - 1;
  localparam int BANK_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = 11;
  localparam int ROW_W      = 12;
  localparam int PIX_W      = $clog2(MAX_WIDTH);
  localparam int HIST_DEPTH = 2 * MAX_DISP;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_AW     = $clog2(OUT_DEPTH);

  localparam logic [10:0] RESET_WIDTH  = 11'd640;
  localparam logic [11:0] RESET_HEIGHT = 12'd480;
  localparam logic [6:0]  RESET_LEVELS = 7'd64;
  localparam logic [7:0]  RESET_SAT    = 8'd40;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LEVELS = 2'd2,
    REG_SAT    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] left_luma;
    logic [15:0] right_luma;
  } in_item_t;

  typedef struct packed {
    logic [7:0] match_cost;
    logic [5:0] disparity;
    logic       last_of_pixel;
  } out_item_t;

  // clamped configuration
  typedef struct packed {
    logic [10:0] width;
    logic [11:0] height;
    logic [6:0]  levels;
    logic [7:0]  sat_cost;
  } cfg_t;

  // seq: running pixel number, the history slot of this pixel's right signature
  typedef struct packed {
    logic [WIN_N-1:0]   left_below;
    logic [WIN_N-1:0]   left_inside;
    logic [PIX_W-1:0]   col;
    logic [HIST_AW-1:0] seq;
  } job_t;

  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    logic [WIN_N-1:0]   data;
  } hist_wr_t;

endpackage

/* hw/rtl/csc_front.sv */
// csc_front: position tracking, row stores, census windows and signatures.
// Pushes one job per emitting pixel; writes right signatures to the history.
// Depends on csc_pkg.
module csc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  csc_pkg::cfg_t     cfg,
  input  logic              restart,
  input  logic              in_push,
  output logic              in_full,
  input  csc_pkg::in_item_t in_data,
  output logic              job_push,
  output csc_pkg::job_t     job,
  input  logic              q_full,
  output csc_pkg::hist_wr_t hist_wr
);

  logic [csc_pkg::COL_W-1:0]  x_r;
  logic [csc_pkg::ROW_W-1:0]  y_r;
  logic [csc_pkg::BANK_W-1:0] bank_r;
  logic [csc_pkg::HIST_AW-1:0] seq_r;

  logic [15:0] lmem [csc_pkg::STORE_ROWS][csc_pkg::MAX_WIDTH];
  logic [15:0] rmem [csc_pkg::STORE_ROWS][csc_pkg::MAX_WIDTH];
  logic [15:0] lrd_r [csc_pkg::STORE_ROWS];
  logic [15:0] rrd_r [csc_pkg::STORE_ROWS];

  logic                       f1_v_r, f1_emit_r;
  logic [csc_pkg::COL_W-1:0]  f1_x_r;
  logic [csc_pkg::ROW_W-1:0]  f1_y_r;
  logic [csc_pkg::BANK_W-1:0] f1_bank_r;
  logic [15:0]                f1_lcur_r, f1_rcur_r;

  logic [15:0] lwin_r [csc_pkg::WIN_H][csc_pkg::WIN_W];
  logic [15:0] rwin_r [csc_pkg::WIN_H][csc_pkg::WIN_W];

  logic                      f2_v_r, f2_emit_r;
  logic [csc_pkg::COL_W-1:0] f2_x_r;
  logic [csc_pkg::ROW_W-1:0] f2_y_r;

  logic adv, accept, in_img, emit;
  logic [15:0] lcol [csc_pkg::WIN_H];
  logic [15:0] rcol [csc_pkg::WIN_H];
  logic [csc_pkg::WIN_N-1:0] lbelow, rbelow, lin;
  logic [csc_pkg::COL_W-1:0] c_full;

  assign adv     = !(f2_v_r && f2_emit_r && q_full);
  assign in_full = !adv;
  assign accept  = in_push && adv;

  assign in_img = (x_r < cfg.width) && (y_r < cfg.height);
  assign emit   = (x_r >= csc_pkg::COL_W'(csc_pkg::HW)) &&
                  (y_r >= csc_pkg::ROW_W'(csc_pkg::HH)) &&
                  ((x_r - csc_pkg::COL_W'(csc_pkg::HW)) < cfg.width) &&
                  ((y_r - csc_pkg::ROW_W'(csc_pkg::HH)) < cfg.height);

  // position counters over the extended frame
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      x_r    <= '0;
      y_r    <= '0;
      bank_r <= '0;
    end else if (accept) begin
      if ({1'b0, x_r} + 12'd1 >= {1'b0, cfg.width} + 12'(csc_pkg::HW)) begin
        x_r <= '0;
        if ({1'b0, y_r} + 13'd1 >= {1'b0, cfg.height} + 13'(csc_pkg::HH)) begin
          y_r    <= '0;
          bank_r <= '0;
        end else begin
          y_r    <= y_r + 1'b1;
          bank_r <= (bank_r == csc_pkg::BANK_W'(csc_pkg::STORE_ROWS - 1)) ?
                    '0 : bank_r + 1'b1;
        end
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  // history slot advances once per pushed pixel, across rows and frames alike
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (job_push) begin
      seq_r <= seq_r + 1'b1;
    end
  end

  // row stores: read the column first, then overwrite the oldest row
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int b = 0; b < csc_pkg::STORE_ROWS; b++) begin
        lrd_r[b] <= lmem[b][x_r[csc_pkg::PIX_W-1:0]];
        rrd_r[b] <= rmem[b][x_r[csc_pkg::PIX_W-1:0]];
        if (in_img && (bank_r == csc_pkg::BANK_W'(b))) begin
          lmem[b][x_r[csc_pkg::PIX_W-1:0]] <= in_data.left_luma;
          rmem[b][x_r[csc_pkg::PIX_W-1:0]] <= in_data.right_luma;
        end
      end
    end
  end

  // window column, top row is y-6
  always_comb begin
    logic [csc_pkg::BANK_W:0] sel;
    for (int i = 0; i < csc_pkg::STORE_ROWS; i++) begin
      sel = {1'b0, f1_bank_r} + (csc_pkg::BANK_W + 1)'(i);
      if (sel >= (csc_pkg::BANK_W + 1)'(csc_pkg::STORE_ROWS))
        sel = sel - (csc_pkg::BANK_W + 1)'(csc_pkg::STORE_ROWS);
      lcol[i] = lrd_r[sel[csc_pkg::BANK_W-1:0]];
      rcol[i] = rrd_r[sel[csc_pkg::BANK_W-1:0]];
    end
    lcol[csc_pkg::WIN_H-1] = f1_lcur_r;
    rcol[csc_pkg::WIN_H-1] = f1_rcur_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
    end
    if (accept) begin
      f1_x_r    <= x_r;
      f1_y_r    <= y_r;
      f1_bank_r <= bank_r;
      f1_emit_r <= emit;
      f1_lcur_r <= in_data.left_luma;
      f1_rcur_r <= in_data.right_luma;
    end
    if (adv) begin
      f2_x_r    <= f1_x_r;
      f2_y_r    <= f1_y_r;
      f2_emit_r <= f1_emit_r;
    end
    if (adv && f1_v_r) begin
      for (int i = 0; i < csc_pkg::WIN_H; i++) begin
        for (int j = 0; j < csc_pkg::WIN_W - 1; j++) begin
          lwin_r[i][j] <= lwin_r[i][j+1];
          rwin_r[i][j] <= rwin_r[i][j+1];
        end
        lwin_r[i][csc_pkg::WIN_W-1] <= lcol[i];
        rwin_r[i][csc_pkg::WIN_W-1] <= rcol[i];
      end
    end
  end

  // signatures and inside mask of the pixel at the window centre
  always_comb begin
    logic [12:0] tx, ty;
    logic        rok, cok;
    for (int i = 0; i < csc_pkg::WIN_H; i++) begin
      for (int j = 0; j < csc_pkg::WIN_W; j++) begin
        tx  = 13'(f2_x_r) + 13'(j);
        ty  = 13'(f2_y_r) + 13'(i);
        cok = (tx >= 13'(2 * csc_pkg::HW)) &&
              ((tx - 13'(2 * csc_pkg::HW)) < 13'(cfg.width));
        rok = (ty >= 13'(2 * csc_pkg::HH)) &&
              ((ty - 13'(2 * csc_pkg::HH)) < 13'(cfg.height));
        lin[i*csc_pkg::WIN_W + j]    = cok && rok;
        lbelow[i*csc_pkg::WIN_W + j] = lwin_r[i][j] < lwin_r[csc_pkg::HH][csc_pkg::HW];
        rbelow[i*csc_pkg::WIN_W + j] = rwin_r[i][j] < rwin_r[csc_pkg::HH][csc_pkg::HW];
      end
    end
  end

  assign c_full   = f2_x_r - csc_pkg::COL_W'(csc_pkg::HW);
  assign job_push = f2_v_r && f2_emit_r && !q_full;

  assign job.left_below  = lbelow;
  assign job.left_inside = lin;
  assign job.col         = c_full[csc_pkg::PIX_W-1:0];
  assign job.seq         = seq_r;

  assign hist_wr.en   = job_push;
  assign hist_wr.addr = seq_r;
  assign hist_wr.data = rbelow;

endmodule

/* hw/rtl/csc_queue.sv */
// csc_queue: two-entry job queue between the front and the cost engine.
// Depends on csc_pkg.
module csc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  csc_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output csc_pkg::job_t dout,
  output logic          empty
);

  csc_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= din;
  end

endmodule

/* hw/rtl/csc_back.sv */
// csc_back: per-disparity cost engine with right signature history and result queue.
// One disparity per cycle while a job is queued and the result queue has room. Depends on csc_pkg.
module csc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  csc_pkg::cfg_t      cfg,
  input  csc_pkg::job_t      job,
  input  logic               q_empty,
  output logic               q_pop,
  input  csc_pkg::hist_wr_t  hist_wr,
  output logic               out_empty,
  input  logic               out_pop,
  output csc_pkg::out_item_t out_data
);

  logic [csc_pkg::WIN_N-1:0] hist [csc_pkg::HIST_DEPTH];
  logic [csc_pkg::WIN_N-1:0] hrd_r;

  logic [5:0] l_r;
  logic       s1_v_r, s1_last_r, s1_sat_r;
  logic [5:0] s1_l_r;
  logic [csc_pkg::PIX_W-1:0] s1_cr_r;
  logic [csc_pkg::WIN_N-1:0] s1_lbelow_r, s1_lin_r;

  csc_pkg::out_item_t     oq_r [csc_pkg::OUT_DEPTH];
  logic [csc_pkg::OUT_AW-1:0] owp_r, orp_r;
  logic [csc_pkg::OUT_AW:0]   ocnt_r;

  logic issue, last, sat, opop;
  logic [csc_pkg::PIX_W-1:0]   cr;
  logic [csc_pkg::HIST_AW-1:0] haddr;
  logic [csc_pkg::WIN_W-1:0]   rcol;
  logic [csc_pkg::WIN_N-1:0]   diff;
  logic [5:0]                  cnt;
  csc_pkg::out_item_t          item;

  assign issue = !q_empty &&
                 ((ocnt_r + (csc_pkg::OUT_AW + 1)'(s1_v_r)) <
                  (csc_pkg::OUT_AW + 1)'(csc_pkg::OUT_DEPTH));
  assign last  = ({1'b0, l_r} == cfg.levels - 7'd1);
  assign sat   = (csc_pkg::PIX_W'(l_r) > job.col);
  assign cr    = job.col - csc_pkg::PIX_W'(l_r);
  // right pixel l columns back is l pixels back in push order
  assign haddr = job.seq - csc_pkg::HIST_AW'(l_r);
  assign q_pop = issue && last;

  always_ff @(posedge clk) begin
    if (hist_wr.en) hist[hist_wr.addr] <= hist_wr.data;
    if (issue) hrd_r <= hist[haddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_r    <= '0;
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      if (issue) l_r <= last ? '0 : l_r + 1'b1;
    end
    if (issue) begin
      s1_l_r      <= l_r;
      s1_last_r   <= last;
      s1_sat_r    <= sat;
      s1_cr_r     <= cr;
      s1_lbelow_r <= job.left_below;
      s1_lin_r    <= job.left_inside;
    end
  end

  // right pixel column inside test, then count of differing positions
  always_comb begin
    logic [11:0] t;
    for (int j = 0; j < csc_pkg::WIN_W; j++) begin
      t       = 12'(s1_cr_r) + 12'(j);
      rcol[j] = (t >= 12'(csc_pkg::HW)) &&
                ((t - 12'(csc_pkg::HW)) < 12'(cfg.width));
    end
  end

  assign diff = s1_lin_r & {csc_pkg::WIN_H{rcol}} & (s1_lbelow_r ^ hrd_r);
  assign cnt  = 6'($countones(diff));

  assign item.match_cost    = s1_sat_r ? cfg.sat_cost : {2'b00, cnt};
  assign item.disparity     = s1_l_r;
  assign item.last_of_pixel = s1_last_r;

  assign out_empty = (ocnt_r == '0);
  assign opop      = out_pop && !out_empty;
  assign out_data  = oq_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (s1_v_r) owp_r <= owp_r + 1'b1;
      if (opop)   orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + (csc_pkg::OUT_AW + 1)'(s1_v_r) - (csc_pkg::OUT_AW + 1)'(opop);
    end
    if (s1_v_r) oq_r[owp_r] <= item;
  end

endmodule

/* hw/rtl/census_stereo_cost.sv */
// census_stereo_cost: census stereo matching cost, top level.
// Throughput: one cost per cycle while a job waits and the result queue has room; a pixel
// gives one cost per disparity level. Inputs that emit nothing pass the front at one per cycle
// unless a full job queue stalls it. Costs ready before they are popped wait in a 4-entry
// result queue. Synchronous active-low reset clears position, queues and pipeline; registers
// return to 640, 480, 64, 40. Row stores need no clearing.
module census_stereo_cost (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  csc_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output csc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  csc_pkg::cfg_reg_t  cfg_index,
  input  logic [11:0]        cfg_data
);

  logic [10:0] fw_r;
  logic [11:0] fh_r;
  logic [6:0]  dl_r;
  logic [7:0]  sc_r;
  logic        cfg_wr, restart;
  csc_pkg::cfg_t     cfg;
  csc_pkg::job_t     job_in, job_out;
  csc_pkg::hist_wr_t hist_wr;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign restart   = cfg_wr && (cfg_index == csc_pkg::REG_WIDTH ||
                                cfg_index == csc_pkg::REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= csc_pkg::RESET_WIDTH;
      fh_r <= csc_pkg::RESET_HEIGHT;
      dl_r <= csc_pkg::RESET_LEVELS;
      sc_r <= csc_pkg::RESET_SAT;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        csc_pkg::REG_WIDTH:  fw_r <= cfg_data[10:0];
        csc_pkg::REG_HEIGHT: fh_r <= cfg_data;
        csc_pkg::REG_LEVELS: dl_r <= cfg_data[6:0];
        csc_pkg::REG_SAT:    sc_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  assign cfg.width  = (fw_r == '0) ? 11'd1 :
                      (fw_r > 11'(csc_pkg::MAX_WIDTH)) ? 11'(csc_pkg::MAX_WIDTH) : fw_r;
  assign cfg.height = (fh_r == '0) ? 12'd1 :
                      (fh_r > 12'(csc_pkg::MAX_HEIGHT)) ? 12'(csc_pkg::MAX_HEIGHT) : fh_r;
  assign cfg.levels = (dl_r == '0) ? 7'd1 :
                      (dl_r > 7'(csc_pkg::MAX_DISP)) ? 7'(csc_pkg::MAX_DISP) : dl_r;
  assign cfg.sat_cost = sc_r;

  csc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .restart  (restart),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .job_push (q_push),
    .job      (job_in),
    .q_full   (q_full),
    .hist_wr  (hist_wr)
  );

  csc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (job_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (job_out),
    .empty (q_empty)
  );

  csc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job       (job_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .hist_wr   (hist_wr),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("job queue underflow");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full)) else $error("bad state after reset");

endmodule

/* dv/census_stereo_cost_test.sv */
// census_stereo_cost_test: self-checking testbench for the census stereo cost block.
// Needs csc_pkg and census_stereo_cost. Costs are predicted in-bench and checked in order.
module census_stereo_cost_test;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    bit          typed;  // expected costs written out by hand
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  csc_pkg::in_item_t  in_data;
  logic               out_empty;
  logic               out_pop;
  csc_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  csc_pkg::cfg_reg_t  cfg_index;
  logic [11:0]        cfg_data;

  census_stereo_cost dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the block
  logic [15:0] left_rows[csc_pkg::WIN_H][csc_pkg::MAX_WIDTH];
  logic [15:0] right_rows[csc_pkg::WIN_H][csc_pkg::MAX_WIDTH];
  int unsigned col_pos, row_pos;
  int unsigned width_reg, height_reg, levels_reg, sat_reg;

  csc_pkg::out_item_t cost_q[$];
  int          errors;
  int unsigned cycles;
  int unsigned popped;
  bit          idling;

  // 1x1 frame, 4 levels: pixel (0,0) emits on the last padded position
  stim_row_t dir_tbl[20] = '{
    '{16'h0000, 16'hffff, 0}, '{16'hffff, 16'h0000, 0}, '{16'h8000, 16'h0001, 0},
    '{16'h00ff, 16'hff00, 0}, '{16'h5555, 16'haaaa, 0}, '{16'haaaa, 16'h5555, 0},
    '{16'h0001, 16'h8000, 0}, '{16'hffff, 16'hffff, 0}, '{16'h0000, 16'h0000, 0},
    '{16'h1234, 16'h4321, 0}, '{16'hffff, 16'h0000, 0}, '{16'h0000, 16'hffff, 0},
    '{16'h7fff, 16'h7fff, 0}, '{16'h0100, 16'h0100, 0}, '{16'hfffe, 16'h0002, 0},
    '{16'hffff, 16'hffff, 0}, '{16'h0000, 16'h0000, 0}, '{16'hc3c3, 16'h3c3c, 0},
    '{16'h0f0f, 16'hf0f0, 0}, '{16'hffff, 16'h0000, 1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    return (v == 0) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // 0 outside, 1 below centre, 2 not below
  function automatic int census_code(bit is_left, int cx, int cy, int dx, int dy,
                                     int w, int h);
    int nx, ny;
    logic [15:0] ctr, nb;
    nx = cx + dx;
    ny = cy + dy;
    if (nx < 0 || nx >= w || ny < 0 || ny >= h) return 0;
    ctr = is_left ? left_rows[cy % csc_pkg::WIN_H][cx] : right_rows[cy % csc_pkg::WIN_H][cx];
    nb  = is_left ? left_rows[ny % csc_pkg::WIN_H][nx] : right_rows[ny % csc_pkg::WIN_H][nx];
    return (nb < ctr) ? 1 : 2;
  endfunction

  function automatic int hamming_cost(int c, int r, int l, int w, int h);
    int n, a, b;
    n = 0;
    for (int dy = -csc_pkg::HH; dy <= csc_pkg::HH; dy++)
      for (int dx = -csc_pkg::HW; dx <= csc_pkg::HW; dx++) begin
        a = census_code(1, c, r, dx, dy, w, h);
        b = census_code(0, c - l, r, dx, dy, w, h);
        if (a != 0 && b != 0 && a != b) n++;
      end
    return n;
  endfunction

  // advance the shadow by one sample; queue its costs unless typed ones take over
  task automatic predict_costs(csc_pkg::in_item_t d, bit typed);
    int unsigned w, h, lv;
    int c, r;
    csc_pkg::out_item_t o;
    w  = clampv(width_reg, csc_pkg::MAX_WIDTH);
    h  = clampv(height_reg, csc_pkg::MAX_HEIGHT);
    lv = clampv(levels_reg, csc_pkg::MAX_DISP);
    if (col_pos < w && row_pos < h) begin
      left_rows[row_pos % csc_pkg::WIN_H][col_pos]  = d.left_luma;
      right_rows[row_pos % csc_pkg::WIN_H][col_pos] = d.right_luma;
    end
    if (col_pos >= csc_pkg::HW && row_pos >= csc_pkg::HH &&
        col_pos - csc_pkg::HW < w && row_pos - csc_pkg::HH < h) begin
      c = col_pos - csc_pkg::HW;
      r = row_pos - csc_pkg::HH;
      for (int l = 0; l < lv; l++) begin
        if (typed)
          o.match_cost = (l == 0) ? 8'd0 : sat_reg[7:0];
        else if (l > c)
          o.match_cost = sat_reg[7:0];
        else
          o.match_cost = 8'(hamming_cost(c, r, l, w, h));
        o.disparity     = l[5:0];
        o.last_of_pixel = (l == lv - 1);
        cost_q.push_back(o);
      end
    end
    col_pos++;
    if (col_pos >= w + csc_pkg::HW) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h + csc_pkg::HH) row_pos = 0;
    end
  endtask

  task automatic send_sample(csc_pkg::in_item_t d, bit typed);
    int gap;
    gap = idling ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_full);
    predict_costs(d, typed);
  endtask

  task automatic write_reg(csc_pkg::cfg_reg_t idx, int unsigned val);
    in_push   <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[11:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      csc_pkg::REG_WIDTH: begin
        width_reg = val & 'h7ff; col_pos = 0; row_pos = 0;
      end
      csc_pkg::REG_HEIGHT: begin
        height_reg = val & 'hfff; col_pos = 0; row_pos = 0;
      end
      csc_pkg::REG_LEVELS: levels_reg = val & 'h7f;
      csc_pkg::REG_SAT:    sat_reg    = val & 'hff;
      default: ;
    endcase
  endtask

  task automatic setup_frame(int unsigned w, int unsigned h, int unsigned lv, int unsigned s);
    write_reg(csc_pkg::REG_WIDTH, w);
    write_reg(csc_pkg::REG_HEIGHT, h);
    write_reg(csc_pkg::REG_LEVELS, lv);
    write_reg(csc_pkg::REG_SAT, s);
  endtask

  function automatic csc_pkg::in_item_t rand_sample(bit narrow);
    csc_pkg::in_item_t d;
    d.left_luma  = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
    d.right_luma = narrow ? 16'($urandom_range(0, 3)) : 16'($urandom);
    return d;
  endfunction

  // result side: random pops, one long hold after the 200th cost
  initial begin
    int gap;
    csc_pkg::out_item_t want;
    out_pop = 1'b0;
    popped  = 0;
    @(posedge rst_n);
    forever begin
      gap = idling ? $urandom_range(0, 9) : 0;
      if (popped == 200) gap = 400;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      popped++;
      if (cost_q.size() == 0) begin
        $display("%0t unexpected cost: actual %p", $time, out_data);
        errors++;
      end else begin
        want = cost_q.pop_front();
        if (out_data.match_cost != want.match_cost ||
            out_data.disparity != want.disparity ||
            out_data.last_of_pixel != want.last_of_pixel) begin
          $display("%0t cost mismatch: expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned sent, w, h, frame_len, extra;
    csc_pkg::in_item_t d;
    bit narrow;
    rst_n     = 1'b0;
    in_push   = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = csc_pkg::REG_WIDTH;
    cfg_data  = '0;
    errors    = 0;
    cycles    = 0;
    idling    = 1'b1;
    col_pos   = 0;
    row_pos   = 0;
    width_reg  = csc_pkg::RESET_WIDTH;
    height_reg = csc_pkg::RESET_HEIGHT;
    levels_reg = csc_pkg::RESET_LEVELS;
    sat_reg    = csc_pkg::RESET_SAT;
    for (int i = 0; i < csc_pkg::WIN_H; i++)
      for (int j = 0; j < csc_pkg::MAX_WIDTH; j++) begin
        left_rows[i][j]  = '0;
        right_rows[i][j] = '0;
      end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one padded single-pixel frame
    setup_frame(1, 1, 4, 255);
    foreach (dir_tbl[i]) begin
      d.left_luma  = dir_tbl[i].left;
      d.right_luma = dir_tbl[i].right;
      send_sample(d, dir_tbl[i].typed);
    end
    // out-of-range zeros act as one
    setup_frame(0, 0, 0, 0);
    for (int i = 0; i < 20; i++) send_sample(rand_sample(0), 0);
    // top extremes: only the start of the first row, which emits nothing
    setup_frame(2047, 4095, 127, 255);
    for (int i = 0; i < 8; i++) send_sample(rand_sample(0), 0);
    setup_frame(csc_pkg::MAX_WIDTH, csc_pkg::MAX_HEIGHT, csc_pkg::MAX_DISP, 0);
    for (int i = 0; i < 6; i++) send_sample(rand_sample(0), 0);

    sent = 0;
    while (sent < 350) begin
      idling = ($urandom_range(0, 3) != 0);
      narrow = ($urandom_range(0, 2) == 0);
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      h = $urandom_range(1, 5);
      case ($urandom_range(0, 3))
        0:       setup_frame(w, h, 1, $urandom_range(0, 255));
        1:       setup_frame(w, h, csc_pkg::MAX_DISP, $urandom_range(0, 255));
        default: setup_frame(w, h, $urandom_range(1, 16), $urandom_range(0, 255));
      endcase
      frame_len = (w + csc_pkg::HW) * (h + csc_pkg::HH);
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, w + csc_pkg::HW) : 0;
      for (int i = 0; i < frame_len + extra; i++) send_sample(rand_sample(narrow), 0);
      sent += frame_len + extra;
      // levels and saturation change without a restart, mid-frame when extra samples were sent
      if ($urandom_range(0, 2) == 0) begin
        write_reg(csc_pkg::REG_LEVELS, $urandom_range(1, csc_pkg::MAX_DISP));
        write_reg(csc_pkg::REG_SAT, $urandom_range(0, 255));
        for (int i = 0; i < frame_len; i++) send_sample(rand_sample(narrow), 0);
        sent += frame_len;
      end
    end
    in_push <= 1'b0;

    while (cost_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/csc_pkg.sv
hw/rtl/csc_front.sv
hw/rtl/csc_queue.sv
hw/rtl/csc_back.sv
hw/rtl/census_stereo_cost.sv
dv/census_stereo_cost_test.sv
